FILE: rtl/bmas_pkg.sv
`timescale 1ns / 1ps

package bmas_pkg;

  // Window lengths and coordinate width.
  localparam int POS_WINDOW  = 8;
  localparam int SIZE_WINDOW = 16;
  localparam int COORD_BITS  = 12;

  // The frame count stops at the longer window.
  localparam int FULL_COUNT = (POS_WINDOW > SIZE_WINDOW) ? POS_WINDOW : SIZE_WINDOW;
  localparam int FRAME_W    = $clog2(FULL_COUNT + 1);

  // Ring index widths (at least one bit, also for a window of one).
  localparam int POS_IDX_W  = (POS_WINDOW > 1) ? $clog2(POS_WINDOW) : 1;
  localparam int SIZE_IDX_W = (SIZE_WINDOW > 1) ? $clog2(SIZE_WINDOW) : 1;

  // Running sums hold a full window of coordinates.
  localparam int POS_SUM_W  = COORD_BITS + $clog2(POS_WINDOW);
  localparam int SIZE_SUM_W = COORD_BITS + $clog2(SIZE_WINDOW);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t box_x;
    coord_t box_y;
    coord_t box_width;
    coord_t box_height;
    logic   detected;
  } box_in_t;

  typedef struct packed {
    coord_t smooth_x;
    coord_t smooth_y;
    coord_t smooth_width;
    coord_t smooth_height;
    logic   tracking;
  } box_out_t;

endpackage

FILE: rtl/box_moving_average_smoother.sv
`timescale 1ns / 1ps

// Box moving-average smoother. Each input transfer carries one detected bounding box and a
// detected flag, and produces exactly one result, which is offered on the output from the
// next cycle on and held there until the output side takes it. A new box can be
// taken in every cycle: the whole update is a ring read, one subtract and one add per running
// sum, and a constant divide, all between the state registers and the output register. The
// output register lets the next box enter in the cycle in which the previous result is taken; the
// input side stalls only while a result is held and the output side stalls. Until the first
// detection, boxes pass straight through with tracking low and nothing is recorded. After it,
// every box (detected or not) enters the position ring of POS_WINDOW entries and the size ring
// of SIZE_WINDOW entries. While the position ring is warming up the box passes through; once
// POS_WINDOW earlier boxes are recorded, x and y become truncated means; once SIZE_WINDOW
// earlier boxes are recorded, width and height do too. Only reset clears the history.
module box_moving_average_smoother (
  input  logic              clk,
  input  logic              rst,
  input  logic              box_valid,
  output logic              box_stall,
  input  bmas_pkg::box_in_t box,
  output logic              smooth_valid,
  input  logic              smooth_stall,
  output bmas_pkg::box_out_t smooth
);
  import bmas_pkg::*;

  // Tracking state.
  logic                  seen_flag;
  logic [FRAME_W-1:0]    frame_count;
  logic [POS_IDX_W-1:0]  pos_ptr;
  logic [SIZE_IDX_W-1:0] size_ptr;

  // Ring histories; an entry is read only after the ring has wrapped once.
  coord_t pos_x_history  [POS_WINDOW];
  coord_t pos_y_history  [POS_WINDOW];
  coord_t size_w_history [SIZE_WINDOW];
  coord_t size_h_history [SIZE_WINDOW];

  // Running sums of the rings.
  logic [POS_SUM_W-1:0]  pos_x_sum;
  logic [POS_SUM_W-1:0]  pos_y_sum;
  logic [SIZE_SUM_W-1:0] size_w_sum;
  logic [SIZE_SUM_W-1:0] size_h_sum;

  logic [POS_SUM_W-1:0]  pos_x_sum_next;
  logic [POS_SUM_W-1:0]  pos_y_sum_next;
  logic [SIZE_SUM_W-1:0] size_w_sum_next;
  logic [SIZE_SUM_W-1:0] size_h_sum_next;

  logic                  accept;
  logic                  record;
  logic                  pos_full;
  logic                  size_full;
  coord_t                pos_x_drop;
  coord_t                pos_y_drop;
  coord_t                size_w_drop;
  coord_t                size_h_drop;
  box_out_t              result;

  // A transfer on the output side frees the result register in the same cycle.
  assign box_stall = smooth_valid && smooth_stall;
  assign accept    = box_valid && !box_stall;

  // Once a detection has been seen, every box is recorded.
  assign record    = seen_flag || box.detected;
  assign pos_full  = frame_count >= FRAME_W'(POS_WINDOW);
  assign size_full = frame_count >= FRAME_W'(SIZE_WINDOW);

  // The oldest entry leaves the sum only once its ring is full.
  assign pos_x_drop  = pos_full  ? pos_x_history[pos_ptr]   : '0;
  assign pos_y_drop  = pos_full  ? pos_y_history[pos_ptr]   : '0;
  assign size_w_drop = size_full ? size_w_history[size_ptr] : '0;
  assign size_h_drop = size_full ? size_h_history[size_ptr] : '0;

  assign pos_x_sum_next  = pos_x_sum  - POS_SUM_W'(pos_x_drop)   + POS_SUM_W'(box.box_x);
  assign pos_y_sum_next  = pos_y_sum  - POS_SUM_W'(pos_y_drop)   + POS_SUM_W'(box.box_y);
  assign size_w_sum_next = size_w_sum - SIZE_SUM_W'(size_w_drop) + SIZE_SUM_W'(box.box_width);
  assign size_h_sum_next = size_h_sum - SIZE_SUM_W'(size_h_drop) + SIZE_SUM_W'(box.box_height);

  always_comb begin
    result.smooth_x      = box.box_x;
    result.smooth_y      = box.box_y;
    result.smooth_width  = box.box_width;
    result.smooth_height = box.box_height;
    result.tracking      = record;
    if (record && pos_full) begin
      result.smooth_x = COORD_BITS'(pos_x_sum_next / POS_WINDOW);
      result.smooth_y = COORD_BITS'(pos_y_sum_next / POS_WINDOW);
      if (size_full) begin
        result.smooth_width  = COORD_BITS'(size_w_sum_next / SIZE_WINDOW);
        result.smooth_height = COORD_BITS'(size_h_sum_next / SIZE_WINDOW);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flag    <= 1'b0;
      frame_count  <= '0;
      pos_ptr      <= '0;
      size_ptr     <= '0;
      pos_x_sum    <= '0;
      pos_y_sum    <= '0;
      size_w_sum   <= '0;
      size_h_sum   <= '0;
      smooth_valid <= 1'b0;
    end else begin
      if (accept) begin
        smooth_valid <= 1'b1;
      end else if (!smooth_stall) begin
        smooth_valid <= 1'b0;
      end
      if (accept && record) begin
        seen_flag  <= 1'b1;
        pos_x_sum  <= pos_x_sum_next;
        pos_y_sum  <= pos_y_sum_next;
        size_w_sum <= size_w_sum_next;
        size_h_sum <= size_h_sum_next;
        pos_ptr    <= (pos_ptr == POS_IDX_W'(POS_WINDOW - 1)) ? '0 : pos_ptr + 1'b1;
        size_ptr   <= (size_ptr == SIZE_IDX_W'(SIZE_WINDOW - 1)) ? '0 : size_ptr + 1'b1;
        if (frame_count < FRAME_W'(FULL_COUNT)) begin
          frame_count <= frame_count + 1'b1;
        end
      end
    end
  end

  // History and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      smooth <= result;
      if (record) begin
        pos_x_history[pos_ptr]   <= box.box_x;
        pos_y_history[pos_ptr]   <= box.box_y;
        size_w_history[size_ptr] <= box.box_width;
        size_h_history[size_ptr] <= box.box_height;
      end
    end
  end

  // Nothing is recorded before the first detection.
  assert property (@(posedge clk) disable iff (rst)
    !seen_flag |-> (frame_count == '0 && pos_x_sum == '0 && size_w_sum == '0))
    else $error("history recorded before the first detection");

  // The frame count saturates at the longer window.
  assert property (@(posedge clk) disable iff (rst)
    frame_count <= FRAME_W'(FULL_COUNT))
    else $error("frame count beyond the full window");

  // During position warm-up the ring pointer follows the frame count.
  assert property (@(posedge clk) disable iff (rst)
    !pos_full |-> (FRAME_W'(pos_ptr) == frame_count))
    else $error("position ring pointer out of step with frame count");

  // A tracking result always leaves the tracker armed.
  assert property (@(posedge clk) disable iff (rst)
    (smooth_valid && smooth.tracking) |-> seen_flag)
    else $error("tracking result without a recorded detection");

endmodule
